// File: rtl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_PAIRS_DEF  = 512;
    localparam int MAX_ORDERS_DEF = 11;

    localparam logic [1:0] CFG_MIN_SHIFT  = 2'd0;
    localparam logic [1:0] CFG_MAX_SHIFT  = 2'd1;
    localparam logic [1:0] CFG_POOL_BYTES = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ARG  = 2'd1,
        ST_NO_FREE  = 2'd2,
        ST_INIT_ERR = 2'd3
    } t_status;

    // pair record status
    typedef enum logic [1:0] {
        PS_FREE      = 2'd0,
        PS_LOW_FREE  = 2'd1,
        PS_HIGH_FREE = 2'd2,
        PS_RESERVED  = 2'd3
    } t_pst;

    typedef struct packed {
        logic [3:0] ord;
        t_pst       st;
    } t_rec;

    typedef struct packed {
        t_op         op;
        logic [31:0] request_bytes;
        logic [25:0] free_offset;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [25:0] block_offset;
        logic [26:0] free_bytes;
    } t_out;

    // command to the free list unit
    typedef struct packed {
        logic       add;
        logic       rem;
        logic       clr;
        logic [4:0] ord;
    } t_lst_cmd;

    // bytes of one block of the given order, modulo the free byte width
    function automatic logic [26:0] f_blk_bytes(input logic [4:0] eff_min,
                                                input logic [4:0] ord);
        logic [5:0] sh;
        sh = {1'b0, eff_min} + {1'b0, ord};
        if (sh < 6'd27) begin
            return 27'd1 << sh;
        end
        return '0;
    endfunction

endpackage

// File: rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over pair records, with one free list per order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_in_req  (t_in)
//  result    out        o_out_valid / i_out_stall  o_out_rsp (t_out)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
//  one request at a time through a sequencer around the record RAM; one
//  record access per cycle, read data registered
//  allocate: order search, list probes, pair read, unlink, reserve, then
//  one split step per order; free: record read and check, then per merge a
//  buddy check, unlink and two record writes; init: clearing pass, block loads
//  after reset a clearing pass over all NUM_PAIRS records runs before the first
//  request is taken; config writes are taken at any time
//  a finished result waits in the output register while the next request
//  is taken; the sequencer waits on the list unit and when that register is still full
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int NUM_PAIRS  = bba_pkg::NUM_PAIRS_DEF,
    parameter int MAX_ORDERS = bba_pkg::MAX_ORDERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bba_pkg::t_in  i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bba_pkg::t_out o_out_rsp,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [26:0]   i_cfg_wdata
);
    import bba_pkg::*;

    localparam int PW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int IW = PW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_A_ORD, S_A_SRCH, S_A_RDP, S_A_GETP, S_A_RES,
        S_A_SPLP, S_A_SPLB, S_F_RD, S_F_CHK, S_F_LOOP, S_F_BCHK, S_F_WLO,
        S_F_WHI, S_F_END, S_I_LOAD, S_W_RM, S_DONE
    } t_state;

    function automatic logic [PW-1:0] f_pix(input logic [31:0] x);
        if (x < 32'(NUM_PAIRS)) begin
            return x[PW-1:0];
        end
        return '0;
    endfunction

    // state and registered outputs
    t_state        r_state, r_ret;
    logic [4:0]    r_min_shift, r_max_shift;
    logic [26:0]   r_pool_bytes;
    logic [4:0]    r_eff_min;
    logic [3:0]    r_eff_k;
    logic [26:0]   r_eff_pool;
    logic [31:0]   r_req;
    logic [3:0]    r_o, r_d, r_sz, r_pord;
    logic [4:0]    r_s;
    logic [PW-1:0] r_p, r_t, r_bd, r_clr;
    logic          r_high;
    logic [IW-1:0] r_i;
    t_status       r_status;
    logic [25:0]   r_offset;
    logic          r_out_valid;
    t_out          r_out;

    // record RAM and list unit controls
    logic          rec_we;
    logic [PW-1:0] rec_waddr, rec_raddr;
    t_rec          rec_wdata, rec_rd;
    t_lst_cmd      lst_cmd;
    logic [PW-1:0] lst_idx, lst_tail;
    logic          lst_nonempty, lst_busy;
    logic [26:0]   lst_free;

    logic          in_acc;
    logic          out_load;
    logic          w_fits;
    logic [3:0]    w_dd;
    logic [PW-1:0] w_split_bd, w_lo, w_hi, w_merge_bd, w_chk_bd, w_pidx, w_idx;
    logic          w_can_merge;
    logic          w_off_ok;
    logic [25:0]   w_phys;
    logic [4:0]    w_k;
    logic          w_init_ok;
    logic [26:0]   w_nmax;
    logic [31:0]   w_idx32;
    logic          w_load;
    logic [31:0]   w_off_out;
    t_pst          w_end_st;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // allocate: does the request fit a block of order r_o
    assign w_fits = {1'b0, r_req} <= (33'd1 << ({1'b0, r_eff_min} + {2'b0, r_o}));

    // split step: the buddy of p at the new order
    assign w_dd       = r_d - 4'd1;
    assign w_split_bd = (w_dd == 4'd0) ? r_p
                      : f_pix(32'(r_p) ^ (32'd1 << (w_dd - 4'd1)));

    // merge step
    assign w_lo        = (r_t < r_bd) ? r_t : r_bd;
    assign w_hi        = (r_t < r_bd) ? r_bd : r_t;
    assign w_merge_bd  = f_pix(32'(w_lo) ^ (32'd1 << r_sz));
    assign w_chk_bd    = (rec_rd.ord == 4'd0) ? r_p
                       : f_pix(32'(r_p) ^ (32'd1 << (rec_rd.ord - 4'd1)));
    assign w_can_merge = (rec_rd.ord == r_sz) && (rec_rd.st != PS_RESERVED);
    assign w_end_st    = (r_sz != 4'd0) ? PS_FREE
                       : (r_high ? PS_HIGH_FREE : PS_LOW_FREE);

    // free: range check and pair index of the offset
    assign w_off_ok = {1'b0, i_in_req.free_offset} < r_eff_pool;
    assign w_phys   = i_in_req.free_offset >> r_eff_min;
    assign w_pidx   = f_pix(32'(w_phys[25:1]));

    // init: configuration check
    assign w_k       = r_max_shift - r_min_shift;
    assign w_init_ok = (r_min_shift <= 5'd16) && (r_max_shift <= 5'd26)
                    && (r_max_shift > r_min_shift)
                    && (32'(w_k) < 32'(MAX_ORDERS))
                    && ((r_pool_bytes >> r_max_shift) != 27'd0)
                    && (32'((r_pool_bytes >> r_min_shift) >> 1) == 32'(NUM_PAIRS));

    // init: load of the maximum-size blocks
    assign w_nmax  = r_eff_pool >> ({1'b0, r_eff_min} + {2'b0, r_eff_k});
    assign w_idx32 = (32'(r_i) << r_eff_k) >> 1;
    assign w_idx   = w_idx32[PW-1:0];
    assign w_load  = (32'(r_i) < 32'(w_nmax)) && (w_idx32 < 32'(NUM_PAIRS));

    assign w_off_out = 32'({r_p, r_high}) << r_eff_min;

    // record RAM and list command per state
    always_comb begin
        rec_we    = 1'b0;
        rec_waddr = r_p;
        rec_wdata = '0;
        rec_raddr = r_p;
        lst_cmd   = '0;
        lst_idx   = r_p;
        case (r_state)
            S_IDLE: begin
                lst_cmd.clr = in_acc && (i_in_req.op == OP_INIT) && w_init_ok;
            end
            S_CLEAR: begin
                rec_we    = 1'b1;
                rec_waddr = r_clr;
            end
            S_A_SRCH: begin
                lst_cmd.ord = r_s;
            end
            S_A_GETP: begin
                lst_cmd.rem = 1'b1;
                lst_cmd.ord = r_s;
            end
            S_A_RES: begin
                rec_we    = 1'b1;
                rec_wdata = '{ord: r_pord, st: PS_RESERVED};
            end
            S_A_SPLP: begin
                rec_we    = (r_d > r_o);
                rec_wdata = '{ord: w_dd, st: PS_RESERVED};
            end
            S_A_SPLB: begin
                rec_we      = 1'b1;
                rec_waddr   = w_split_bd;
                rec_wdata   = '{ord: w_dd,
                                st: (w_dd == 4'd0) ? PS_HIGH_FREE : PS_FREE};
                lst_cmd.add = 1'b1;
                lst_cmd.ord = {1'b0, w_dd};
                lst_idx     = w_split_bd;
            end
            S_F_LOOP: begin
                rec_raddr = r_bd;
            end
            S_F_BCHK: begin
                lst_cmd.rem = w_can_merge;
                lst_cmd.ord = {1'b0, r_sz};
                lst_idx     = r_bd;
            end
            S_F_WLO: begin
                rec_we    = 1'b1;
                rec_waddr = w_lo;
                rec_wdata = '{ord: r_sz + 4'd1, st: PS_FREE};
            end
            S_F_WHI: begin
                rec_we    = 1'b1;
                rec_waddr = w_hi;
                rec_wdata = '{ord: r_sz + 4'd1, st: PS_FREE};
            end
            S_F_END: begin
                rec_we      = 1'b1;
                rec_waddr   = r_t;
                rec_wdata   = '{ord: r_sz, st: w_end_st};
                lst_cmd.add = 1'b1;
                lst_cmd.ord = {1'b0, r_sz};
                lst_idx     = r_t;
            end
            S_I_LOAD: begin
                rec_we      = w_load;
                rec_waddr   = w_idx;
                rec_wdata   = '{ord: r_eff_k, st: PS_FREE};
                lst_cmd.add = w_load;
                lst_cmd.ord = {1'b0, r_eff_k};
                lst_idx     = w_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ret        <= S_IDLE;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_min_shift  <= 5'd3;
            r_max_shift  <= 5'd7;
            r_pool_bytes <= 27'd8192;
            r_eff_min    <= '0;
            r_eff_k      <= '0;
            r_eff_pool   <= '0;
        end else begin
            // configuration writes; unknown indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_SHIFT:  r_min_shift  <= i_cfg_wdata[4:0];
                    CFG_MAX_SHIFT:  r_max_shift  <= i_cfg_wdata[4:0];
                    CFG_POOL_BYTES: r_pool_bytes <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // output register empties when taken, unless a new result drops in
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_offset <= '0;
                        r_req    <= i_in_req.request_bytes;
                        case (i_in_req.op)
                            OP_ALLOC: begin
                                r_o      <= '0;
                                r_status <= ST_BAD_ARG;
                                r_state  <= (i_in_req.request_bytes != '0) ? S_A_ORD
                                                                           : S_DONE;
                            end
                            OP_FREE: begin
                                r_p      <= w_pidx;
                                r_high   <= w_phys[0];
                                r_status <= ST_BAD_ARG;
                                r_state  <= w_off_ok ? S_F_RD : S_DONE;
                            end
                            OP_INIT: begin
                                if (w_init_ok) begin
                                    // latch the geometry, wipe records, load
                                    r_eff_min  <= r_min_shift;
                                    r_eff_k    <= w_k[3:0];
                                    r_eff_pool <= r_pool_bytes;
                                    r_i        <= '0;
                                    r_clr      <= '0;
                                    r_ret      <= S_I_LOAD;
                                    r_state    <= S_CLEAR;
                                end else begin
                                    r_status <= ST_INIT_ERR;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_status <= ST_BAD_ARG;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (32'(r_clr) == 32'(NUM_PAIRS - 1)) begin
                        r_clr   <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_clr <= r_clr + PW'(1);
                    end
                end
                // smallest order whose block holds the request
                S_A_ORD: begin
                    if (w_fits) begin
                        r_s     <= {1'b0, r_o};
                        r_state <= S_A_SRCH;
                    end else if (r_o == r_eff_k) begin
                        r_state <= S_DONE;
                    end else begin
                        r_o <= r_o + 4'd1;
                    end
                end
                // first non-empty list at that order or above
                S_A_SRCH: begin
                    if ((r_s <= {1'b0, r_eff_k}) && (32'(r_s) < 32'(MAX_ORDERS))) begin
                        if (lst_nonempty) begin
                            r_p     <= lst_tail;
                            r_state <= S_A_RDP;
                        end else begin
                            r_s <= r_s + 5'd1;
                        end
                    end else begin
                        r_status <= ST_NO_FREE;
                        r_state  <= S_DONE;
                    end
                end
                S_A_RDP: r_state <= S_A_GETP;
                S_A_GETP: begin
                    r_high  <= (rec_rd.st == PS_HIGH_FREE);
                    r_pord  <= rec_rd.ord;
                    r_ret   <= S_A_RES;
                    r_state <= S_W_RM;
                end
                S_A_RES: begin
                    r_d     <= r_s[3:0];
                    r_state <= S_A_SPLP;
                end
                // split down, one buddy per order
                S_A_SPLP: begin
                    if (r_d > r_o) begin
                        r_state <= S_A_SPLB;
                    end else begin
                        r_status <= ST_OK;
                        r_offset <= w_off_out[25:0];
                        r_state  <= S_DONE;
                    end
                end
                S_A_SPLB: begin
                    r_d     <= w_dd;
                    r_state <= S_A_SPLP;
                end
                S_W_RM: begin
                    if (!lst_busy) begin
                        r_state <= r_ret;
                    end
                end
                S_F_RD: r_state <= S_F_CHK;
                S_F_CHK: begin
                    if (rec_rd.st == PS_FREE) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sz    <= rec_rd.ord;
                        r_t     <= r_p;
                        r_bd    <= w_chk_bd;
                        r_state <= S_F_LOOP;
                    end
                end
                // merge upward while the buddy is free at the same order
                S_F_LOOP: begin
                    r_state <= (r_sz < r_eff_k) ? S_F_BCHK : S_F_END;
                end
                S_F_BCHK: begin
                    if (w_can_merge) begin
                        r_ret   <= S_F_WLO;
                        r_state <= S_W_RM;
                    end else begin
                        r_state <= S_F_END;
                    end
                end
                S_F_WLO: r_state <= S_F_WHI;
                S_F_WHI: begin
                    r_t     <= w_lo;
                    r_bd    <= w_merge_bd;
                    r_sz    <= r_sz + 4'd1;
                    r_state <= S_F_LOOP;
                end
                S_F_END: begin
                    r_status <= ST_OK;
                    r_state  <= S_DONE;
                end
                S_I_LOAD: begin
                    if (w_load) begin
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{status: r_status, block_offset: r_offset,
                                         free_bytes: lst_free};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pair records: order and half-free status
    bba_ram #(.W($bits(t_rec)), .D(NUM_PAIRS)) u_rec (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(rec_waddr),
        .i_wdata(rec_wdata),
        .i_raddr(rec_raddr),
        .o_rdata(rec_rd)
    );

    bba_lists #(.NUM_PAIRS(NUM_PAIRS), .MAX_ORDERS(MAX_ORDERS)) u_lists (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (lst_cmd),
        .i_idx       (lst_idx),
        .i_eff_min   (r_eff_min),
        .o_nonempty  (lst_nonempty),
        .o_tail      (lst_tail),
        .o_busy      (lst_busy),
        .o_free_bytes(lst_free)
    );

`ifndef ASSERT_OFF
    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_lists_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !lst_busy)
        else $error("list unit busy while sequencer idle");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not loaded into output register");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != ST_OK) |-> (o_out_rsp.block_offset == '0))
        else $error("nonzero offset on failed request");
`endif

endmodule

// File: rtl/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/bba_lists.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_lists
// Per-order doubly linked free lists with tail insertion and free byte total.
// ----------------------------------------------------------------------------
module bba_lists #(
    parameter int NUM_PAIRS  = 512,
    parameter int MAX_ORDERS = 11,
    localparam int PW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_lst_cmd i_cmd,
    input  logic [PW-1:0]     i_idx,
    input  logic [4:0]        i_eff_min,
    output logic              o_nonempty,
    output logic [PW-1:0]     o_tail,
    output logic              o_busy,
    output logic [26:0]       o_free_bytes
);
    import bba_pkg::*;

    localparam int OIW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CW  = $clog2(NUM_PAIRS + 1);

    typedef enum logic {L_IDLE, L_UPD} t_lstate;

    t_lstate       r_st;
    logic [PW-1:0] r_head [MAX_ORDERS];
    logic [PW-1:0] r_tail [MAX_ORDERS];
    logic [CW-1:0] r_cnt  [MAX_ORDERS];
    logic [26:0]   r_free;
    logic [4:0]    r_ord;
    logic [PW-1:0] r_x;

    logic [4:0]     a_ord;
    logic           a_ok;
    logic [OIW-1:0] a_i;
    logic [CW-1:0]  cur_cnt;
    logic [PW-1:0]  cur_head, cur_tail;
    logic [26:0]    delta;

    logic          nxt_we, prv_we;
    logic [PW-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    logic [PW-1:0] nxt_rd, prv_rd;

    assign a_ord    = (r_st == L_UPD) ? r_ord : i_cmd.ord;
    assign a_ok     = 32'(a_ord) < 32'(MAX_ORDERS);
    assign a_i      = a_ord[OIW-1:0];
    assign cur_cnt  = a_ok ? r_cnt[a_i] : '0;
    assign cur_head = a_ok ? r_head[a_i] : '0;
    assign cur_tail = a_ok ? r_tail[a_i] : '0;
    assign delta    = f_blk_bytes(i_eff_min, a_ord);

    assign o_nonempty   = (cur_cnt != '0);
    assign o_tail       = cur_tail;
    assign o_busy       = (r_st == L_UPD);
    assign o_free_bytes = r_free;

    // link writes: append behind the tail, or unlink an entry
    always_comb begin
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        nxt_waddr = cur_tail;
        nxt_wdata = i_idx;
        prv_waddr = i_idx;
        prv_wdata = cur_tail;
        if (r_st == L_IDLE) begin
            if (i_cmd.add && !i_cmd.clr && a_ok && cur_cnt != '0) begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
            end
        end else begin
            nxt_waddr = prv_rd;
            nxt_wdata = nxt_rd;
            prv_waddr = nxt_rd;
            prv_wdata = prv_rd;
            nxt_we    = (r_x != cur_head);
            prv_we    = (r_x != cur_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_free <= '0;
            for (int i = 0; i < MAX_ORDERS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            case (r_st)
                L_IDLE: begin
                    r_ord <= i_cmd.ord;
                    r_x   <= i_idx;
                    if (i_cmd.clr) begin
                        r_free <= '0;
                        for (int i = 0; i < MAX_ORDERS; i++) begin
                            r_head[i] <= '0;
                            r_tail[i] <= '0;
                            r_cnt[i]  <= '0;
                        end
                    end else if (i_cmd.add && a_ok) begin
                        if (cur_cnt == '0) begin
                            r_head[a_i] <= i_idx;
                        end
                        r_tail[a_i] <= i_idx;
                        r_cnt[a_i]  <= cur_cnt + CW'(1);
                        r_free      <= r_free + delta;
                    end else if (i_cmd.rem && a_ok && cur_cnt != '0) begin
                        if (cur_cnt == CW'(1)) begin
                            r_cnt[a_i] <= '0;
                            r_free     <= r_free - delta;
                        end else begin
                            r_st <= L_UPD;
                        end
                    end
                end
                L_UPD: begin
                    if (r_x == cur_head) begin
                        r_head[a_i] <= nxt_rd;
                    end
                    if (r_x == cur_tail) begin
                        r_tail[a_i] <= prv_rd;
                    end
                    r_cnt[a_i] <= cur_cnt - CW'(1);
                    r_free     <= r_free - delta;
                    r_st       <= L_IDLE;
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    bba_ram #(.W(PW), .D(NUM_PAIRS)) u_next (
        .i_clk  (i_clk),
        .i_we   (nxt_we),
        .i_waddr(nxt_waddr),
        .i_wdata(nxt_wdata),
        .i_raddr(i_idx),
        .o_rdata(nxt_rd)
    );

    bba_ram #(.W(PW), .D(NUM_PAIRS)) u_prev (
        .i_clk  (i_clk),
        .i_we   (prv_we),
        .i_waddr(prv_waddr),
        .i_wdata(prv_wdata),
        .i_raddr(i_idx),
        .o_rdata(prv_rd)
    );

endmodule
